// ----- src/msw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msw_pkg
// Shared types, constants and pixel arithmetic for the 3x3 median and Sobel
// window block.
// ----------------------------------------------------------------------------
package msw_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int COL_W        = ADDR_W + 1;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 12;
  localparam int ROW_W        = HEIGHT_REG_W;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd480;

  localparam logic [7:0] MAG_CLAMP = 8'd255;

  typedef logic [7:0] pixel_t;
  // index = row * 3 + column
  typedef logic [8:0][7:0] win_t;

  typedef struct packed {
    logic              pre;       // result from window before this beat's shift
    logic              post;      // result from window after this beat's shift
    logic              last;
    logic              mem;       // line store update and window shift
    logic              pix_row;   // bottom row takes the pixel, lower store written
    logic              top_copy;
    logic              lc_one;
    logic [ADDR_W-1:0] addr;
    pixel_t            pix;
  } s1_ctrl_t;

  function automatic pixel_t min2(pixel_t a, pixel_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pixel_t max2(pixel_t a, pixel_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pixel_t med3(pixel_t a, pixel_t b, pixel_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // row sort, then median of (max of mins, median of medians, min of maxes)
  function automatic pixel_t median9(win_t v);
    pixel_t lo0, lo1, lo2, md0, md1, md2, hi0, hi1, hi2;
    lo0 = min2(min2(v[0], v[1]), v[2]);
    lo1 = min2(min2(v[3], v[4]), v[5]);
    lo2 = min2(min2(v[6], v[7]), v[8]);
    hi0 = max2(max2(v[0], v[1]), v[2]);
    hi1 = max2(max2(v[3], v[4]), v[5]);
    hi2 = max2(max2(v[6], v[7]), v[8]);
    md0 = med3(v[0], v[1], v[2]);
    md1 = med3(v[3], v[4], v[5]);
    md2 = med3(v[6], v[7], v[8]);
    return med3(max2(max2(lo0, lo1), lo2), med3(md0, md1, md2), min2(min2(hi0, hi1), hi2));
  endfunction

  function automatic pixel_t sobel_mag(win_t v);
    logic [9:0]  gxp, gxn, gyp, gyn, ax, ay;
    logic [10:0] m;
    gxp = 10'(v[2]) + {1'b0, v[5], 1'b0} + 10'(v[8]);
    gxn = 10'(v[0]) + {1'b0, v[3], 1'b0} + 10'(v[6]);
    gyp = 10'(v[6]) + {1'b0, v[7], 1'b0} + 10'(v[8]);
    gyn = 10'(v[0]) + {1'b0, v[1], 1'b0} + 10'(v[2]);
    ax  = (gxp >= gxn) ? (gxp - gxn) : (gxn - gxp);
    ay  = (gyp >= gyn) ? (gyp - gyn) : (gyn - gyp);
    m   = {1'b0, ax} + {1'b0, ay};
    return (m > 11'(MAG_CLAMP)) ? MAG_CLAMP : m[7:0];
  endfunction

  // picks three window columns; top_copy repeats the middle row on top
  function automatic win_t take_nbhd(win_t w, logic [2:0][1:0] cols, logic top_copy);
    win_t v;
    int   src;
    v = '0;
    for (int i = 0; i < 3; i++) begin
      src = (i == 0 && top_copy) ? 1 : i;
      for (int j = 0; j < 3; j++) begin
        v[i * 3 + j] = w[src * 3 + int'(cols[j])];
      end
    end
    return v;
  endfunction

endpackage

// ----- src/median_and_sobel_3x3_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_and_sobel_3x3_window
// Raster stream of 8-bit grey pixels in, per pixel the 3x3 median and the
// clamped Sobel magnitude out, with edge replication at the borders.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------
//  in      | in_valid_i / in_ready_o | pixel_value_i, is_flush_i
//  out     | out_valid_o/out_ready_i | median_value_o, edge_magnitude_o,
//          |                         | last_of_frame_o
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat per cycle unless a held result stalls: accept stage (line store read),
// window stage (store write, shift, median and Sobel), output register loaded from
// the window stage. Rate is set by the window stage and one read and one write port
// per store. A pixel's result comes image_width+1 beats after it; flush beats drain.
// Reset clears counters and window; line stores are not cleared.
// A result held with out_ready_i low freezes every stage and drops in_ready_o.
// ----------------------------------------------------------------------------
module median_and_sobel_3x3_window (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  msw_pkg::pixel_t                   pixel_value_i,
  input  logic                              is_flush_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output msw_pkg::pixel_t                   median_value_o,
  output msw_pkg::pixel_t                   edge_magnitude_o,
  output logic                              last_of_frame_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [msw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [msw_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import msw_pkg::*;

  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [COL_W-1:0]        col_q, col_d, c0, c_inc, w_use;
  logic [ROW_W-1:0]        row_q, row_d, r0, h_use;
  logic                    adv, accept, wrap, drain, final0, s1_valid_d, s1_valid_q;
  s1_ctrl_t                ctrl_d, ctrl_q;
  pixel_t                  mem_up [MAX_WIDTH];
  pixel_t                  mem_lo [MAX_WIDTH];
  pixel_t                  rd_up_q, rd_lo_q, bot;
  win_t                    win_q, win_shift, nbhd;
  logic                    out_valid_q, last_q;
  pixel_t                  median_q, edge_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < WIDTH_REG_W'(3)) begin
      w_use = COL_W'(3);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_use = COL_W'(MAX_WIDTH);
    end else begin
      w_use = COL_W'(width_q);
    end
    h_use = (height_q < HEIGHT_REG_W'(3)) ? ROW_W'(3) : height_q;
  end

  // accept stage
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  assign wrap   = (row_q < h_use) && (col_q >= w_use);
  assign c0     = wrap ? '0 : col_q;
  assign r0     = wrap ? row_q + ROW_W'(1) : row_q;
  assign drain  = (r0 >= h_use);
  assign final0 = drain && (c0 >= w_use);
  assign c_inc  = c0 + COL_W'(1);

  always_comb begin
    ctrl_d      = '0;
    ctrl_d.addr = c0[ADDR_W-1:0];
    ctrl_d.pix  = pixel_value_i;
    s1_valid_d  = 1'b0;
    col_d       = c0;
    row_d       = r0;
    if (final0) begin
      s1_valid_d  = 1'b1;
      ctrl_d.pre  = 1'b1;
      ctrl_d.last = 1'b1;
      col_d       = '0;
      row_d       = '0;
    end else if (drain) begin
      s1_valid_d    = 1'b1;
      ctrl_d.pre    = (c0 == '0);
      ctrl_d.post   = (c0 != '0);
      ctrl_d.mem    = 1'b1;
      ctrl_d.lc_one = (c0 == COL_W'(1));
      col_d         = c_inc;
    end else if (!is_flush_i) begin
      s1_valid_d      = 1'b1;
      ctrl_d.pre      = (c0 == '0) && (r0 >= ROW_W'(2));
      ctrl_d.post     = (c0 != '0) && (r0 != '0);
      ctrl_d.top_copy = (c0 == '0) ? (r0 == ROW_W'(2)) : (r0 == ROW_W'(1));
      ctrl_d.mem      = 1'b1;
      ctrl_d.pix_row  = 1'b1;
      ctrl_d.lc_one   = (c0 == COL_W'(1));
      if (c_inc >= w_use) begin
        col_d = '0;
        row_d = r0 + ROW_W'(1);
      end else begin
        col_d = c_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept && s1_valid_d;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctrl_q  <= ctrl_d;
      rd_up_q <= mem_up[ctrl_d.addr];
      rd_lo_q <= mem_lo[ctrl_d.addr];
    end
    if (adv && s1_valid_q && ctrl_q.mem) begin
      mem_up[ctrl_q.addr] <= rd_lo_q;
      if (ctrl_q.pix_row) begin
        mem_lo[ctrl_q.addr] <= ctrl_q.pix;
      end
    end
  end

  // window stage
  assign bot = ctrl_q.pix_row ? ctrl_q.pix : rd_lo_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_shift[r * 3 + 0] = win_q[r * 3 + 1];
      win_shift[r * 3 + 1] = win_q[r * 3 + 2];
    end
    win_shift[2] = rd_up_q;
    win_shift[5] = rd_lo_q;
    win_shift[8] = bot;
    if (ctrl_q.pre) begin
      nbhd = take_nbhd(win_q, {2'd2, 2'd2, 2'd1}, ctrl_q.top_copy);
    end else begin
      nbhd = take_nbhd(win_shift, {2'd2, 2'd1, {1'b0, ctrl_q.lc_one}}, ctrl_q.top_copy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q && (ctrl_q.pre || ctrl_q.post);
      if (s1_valid_q && ctrl_q.mem) begin
        win_q <= win_shift;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      median_q <= median9(nbhd);
      edge_q   <= sobel_mag(nbhd);
      last_q   <= ctrl_q.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_value_o   = median_q;
  assign edge_magnitude_o = edge_q;
  assign last_of_frame_o  = last_q;

  a_pre_post_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !(ctrl_q.pre && ctrl_q.post))
    else $error("both window results requested for one beat");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && final0) |=> (col_q == '0 && row_q == '0))
    else $error("counters not cleared after final result");

  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result without a window stage beat");

  a_last_no_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && ctrl_q.last) |-> (!ctrl_q.mem && ctrl_q.pre))
    else $error("final result touches line stores");

endmodule

// ----- dv/median_and_sobel_3x3_window_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_and_sobel_3x3_window_checker
// Watches the pixel, result and register channels of the 3x3 median and Sobel
// window block. It keeps its own line stores, window and raster counters, works
// out from the accepted pixel beats the results owed, and compares each accepted
// result beat field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module median_and_sobel_3x3_window_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  msw_pkg::pixel_t                pixel_value_i,
  input  logic                           is_flush_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  msw_pkg::pixel_t                median_value_i,
  input  msw_pkg::pixel_t                edge_magnitude_i,
  input  logic                           last_of_frame_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [msw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [msw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             mismatch_cnt_o,
  output int                             pending_cnt_o,
  output int                             result_cnt_o,
  output int                             frame_cnt_o
);

  import msw_pkg::*;

  typedef struct packed {
    pixel_t median;
    pixel_t magnitude;
    logic   last;
  } filt_result_t;

  filt_result_t filtered_q[$];

  pixel_t upper_line [MAX_WIDTH];
  pixel_t lower_line [MAX_WIDTH];
  pixel_t win [9];
  int     col_pos;
  int     row_pos;
  int     width_reg;
  int     height_reg;
  int     mismatches;
  int     results;
  int     frames;

  // window index = row * 3 + column
  function automatic filt_result_t filter_window(int lc, int mc, int rc, bit top_copy,
                                                 bit last);
    int           v [9];
    int           cols [3];
    int           src;
    int           gx;
    int           gy;
    int           mag;
    int           t;
    int           k;
    filt_result_t res;
    cols[0] = lc;
    cols[1] = mc;
    cols[2] = rc;
    for (int i = 0; i < 3; i++) begin
      src = (i == 0 && top_copy) ? 1 : i;
      for (int j = 0; j < 3; j++) begin
        v[i * 3 + j] = int'(win[src * 3 + cols[j]]);
      end
    end
    gx = v[2] + 2 * v[5] + v[8] - v[0] - 2 * v[3] - v[6];
    gy = v[6] + 2 * v[7] + v[8] - v[0] - 2 * v[1] - v[2];
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    mag = gx + gy;
    if (mag > int'(MAG_CLAMP)) mag = int'(MAG_CLAMP);
    for (int i = 1; i < 9; i++) begin
      t = v[i];
      k = i;
      while (k > 0 && v[k - 1] > t) begin
        v[k] = v[k - 1];
        k--;
      end
      v[k] = t;
    end
    res.median    = pixel_t'(v[4]);
    res.magnitude = pixel_t'(mag);
    res.last      = last;
    return res;
  endfunction

  task automatic shift_in_column(pixel_t top, pixel_t mid, pixel_t bot);
    pixel_t col [3];
    col[0] = top;
    col[1] = mid;
    col[2] = bot;
    for (int r = 0; r < 3; r++) begin
      win[r * 3 + 0] = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
      win[r * 3 + 2] = col[r];
    end
  endtask

  task automatic step_window(pixel_t pix, logic flush);
    int     w;
    int     h;
    int     c;
    int     r;
    pixel_t top_v;
    pixel_t mid_v;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = (height_reg < 3) ? 3 : height_reg;
    if (row_pos < h && col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    c = col_pos;
    r = row_pos;
    if (r >= h) begin
      // draining: virtual row repeating the bottom row, pixels are dropped
      if (c >= w) begin
        filtered_q.push_back(filter_window(1, 2, 2, 1'b0, 1'b1));
        frames++;
        col_pos = 0;
        row_pos = 0;
      end else begin
        if (c == 0) filtered_q.push_back(filter_window(1, 2, 2, 1'b0, 1'b0));
        top_v = upper_line[c];
        mid_v = lower_line[c];
        upper_line[c] = mid_v;
        shift_in_column(top_v, mid_v, mid_v);
        if (c >= 1) filtered_q.push_back(filter_window(c == 1 ? 1 : 0, 1, 2, 1'b0, 1'b0));
        col_pos = c + 1;
      end
    end else if (!flush) begin
      if (c == 0 && r >= 2) filtered_q.push_back(filter_window(1, 2, 2, r == 2, 1'b0));
      top_v = upper_line[c];
      mid_v = lower_line[c];
      upper_line[c] = mid_v;
      lower_line[c] = pix;
      shift_in_column(top_v, mid_v, pix);
      if (c >= 1 && r >= 1) begin
        filtered_q.push_back(filter_window(c == 1 ? 1 : 0, 1, 2, r == 1, 1'b0));
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      col_pos = c;
      row_pos = r;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    filt_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      filtered_q.delete();
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = int'(WIDTH_RESET);
      height_reg = int'(HEIGHT_RESET);
      mismatches = 0;
      results    = 0;
      frames     = 0;
      mismatch_cnt_o <= 0;
      pending_cnt_o  <= 0;
      result_cnt_o   <= 0;
      frame_cnt_o    <= 0;
    end else begin
      // a pixel beat on the same edge as a register write still sees the old geometry
      if (in_valid_i && in_ready_i) step_window(pixel_value_i, is_flush_i);
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_IMAGE_WIDTH) begin
          width_reg = int'(cfg_data_i[WIDTH_REG_W-1:0]);
        end else if (cfg_index_i == REG_IMAGE_HEIGHT) begin
          height_reg = int'(cfg_data_i[HEIGHT_REG_W-1:0]);
        end
      end
      if (out_valid_i && out_ready_i) begin
        results++;
        if (filtered_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with none expected (median %0d, magnitude %0d, last %0b)",
                   $time, median_value_i, edge_magnitude_i, last_of_frame_i);
        end else begin
          want = filtered_q.pop_front();
          if (median_value_i !== want.median) begin
            mismatches++;
            $display("%0t: median expected %0d actual %0d", $time, want.median,
                     median_value_i);
          end
          if (edge_magnitude_i !== want.magnitude) begin
            mismatches++;
            $display("%0t: edge magnitude expected %0d actual %0d", $time, want.magnitude,
                     edge_magnitude_i);
          end
          if (last_of_frame_i !== want.last) begin
            mismatches++;
            $display("%0t: last_of_frame expected %0b actual %0b", $time, want.last,
                     last_of_frame_i);
          end
        end
      end
      mismatch_cnt_o <= mismatches;
      pending_cnt_o  <= filtered_q.size();
      result_cnt_o   <= results;
      frame_cnt_o    <= frames;
    end
  end

endmodule

// ----- dv/median_and_sobel_3x3_window_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_and_sobel_3x3_window_tb
// Streams raster frames of many geometries through the window block: a short
// hand-made 3x3 frame first, then random frames under sender gaps, receiver
// stalls and a long output hold, then frames with register values below range.
// The checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module median_and_sobel_3x3_window_tb;

  import msw_pkg::*;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int HOLD_CYCLES      = 300;
  localparam int ITEMS_PER_PHASE  = 180;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {
    STYLE_NOISE,
    STYLE_BINARY,
    STYLE_FLAT,
    STYLE_RAMP
  } pix_style_e;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  pixel_t                pixel_value;
  logic                  is_flush;
  logic                  out_valid;
  logic                  out_ready;
  pixel_t                median_value;
  pixel_t                edge_magnitude;
  logic                  last_of_frame;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_cnt;
  int pending_cnt;
  int result_cnt;
  int frame_cnt;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int beats_sent;
  int cfg_writes;
  int cur_w;
  int cur_h;

  median_and_sobel_3x3_window i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .pixel_value_i    (pixel_value),
    .is_flush_i       (is_flush),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .median_value_o   (median_value),
    .edge_magnitude_o (edge_magnitude),
    .last_of_frame_o  (last_of_frame),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  median_and_sobel_3x3_window_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .pixel_value_i    (pixel_value),
    .is_flush_i       (is_flush),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .median_value_i   (median_value),
    .edge_magnitude_i (edge_magnitude),
    .last_of_frame_i  (last_of_frame),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_cnt_o   (mismatch_cnt),
    .pending_cnt_o    (pending_cnt),
    .result_cnt_o     (result_cnt),
    .frame_cnt_o      (frame_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic pixel_t pick_pixel(pix_style_e style, int x, int y);
    case (style)
      STYLE_NOISE:  return pixel_t'($urandom_range(255));
      STYLE_BINARY: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      STYLE_FLAT:   return pixel_t'(100 + $urandom_range(15));
      default:      return pixel_t'((x * 37 + y * 11) & 255);
    endcase
  endfunction

  // valid stays high across back-to-back beats; send_beat lowers it only on a gap
  task automatic send_beat(pixel_t pix, logic flush);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= pix;
    is_flush    <= flush;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] width_data,
                           logic [CFG_DATA_W-1:0] height_data);
    drain_and_settle();
    write_reg(REG_IMAGE_WIDTH, width_data);
    write_reg(REG_IMAGE_HEIGHT, height_data);
    cfg_valid <= 1'b0;
    cur_w = int'(width_data[WIDTH_REG_W-1:0]);
    if (cur_w < 3) cur_w = 3;
    if (cur_w > MAX_WIDTH) cur_w = MAX_WIDTH;
    cur_h = int'(height_data[HEIGHT_REG_W-1:0]);
    if (cur_h < 3) cur_h = 3;
  endtask

  // stray flushes inside the frame are ignored; drain mixes flushes and dropped pixels
  task automatic send_frame(pix_style_e style, int pause_at);
    int n;
    n = 0;
    for (int y = 0; y < cur_h; y++) begin
      for (int x = 0; x < cur_w; x++) begin
        if ($urandom_range(19) == 0) send_beat(pixel_t'($urandom_range(255)), 1'b1);
        if (n == pause_at) drain_and_settle();
        send_beat(pick_pixel(style, x, y), 1'b0);
        n++;
      end
    end
    for (int k = 0; k <= cur_w; k++) begin
      send_beat(pixel_t'($urandom_range(255)), $urandom_range(2) != 0);
    end
    if ($urandom_range(3) == 0) send_beat(pixel_t'($urandom_range(255)), 1'b1);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, bit hold_first, bit pause_first);
    int                    start;
    bit                    first;
    logic [CFG_DATA_W-1:0] wd;
    logic [CFG_DATA_W-1:0] hd;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = beats_sent;
    first = 1'b1;
    while (beats_sent - start < ITEMS_PER_PHASE) begin
      wd = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(2))
                                    : CFG_DATA_W'($urandom_range(12, 3));
      hd = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(2))
                                    : CFG_DATA_W'($urandom_range(7, 3));
      configure(wd, hd);
      if (first && hold_first) hold_request = HOLD_CYCLES;
      send_frame(pix_style_e'($urandom_range(3)),
                 (first && pause_first) ? (cur_w * cur_h) / 2 : -1);
      first = 1'b0;
    end
  endtask

  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        out_ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no beat on any channel for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("median_and_sobel_3x3_window test failed");
    $finish;
  end

  initial begin : stimulus
    pixel_t directed_pix [9];
    in_valid       = 1'b0;
    pixel_value    = '0;
    is_flush       = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_IMAGE_WIDTH;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    beats_sent     = 0;
    cfg_writes     = 0;
    cur_w          = 3;
    cur_h          = 3;
    rst_n          = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unused index must leave the geometry alone
    write_reg(REG_UNUSED, '1);
    cfg_valid <= 1'b0;

    // checkerboard 3x3: every pixel but the centre on a border, magnitude clamps
    directed_pix = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
    configure(12'd3, 12'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_beat(8'hFF, 1'b1);
      send_beat(directed_pix[i], 1'b0);
    end
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'h00, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);

    run_phase(0, 0, 1'b1, 1'b0);
    run_phase(88, 0, 1'b0, 1'b0);
    run_phase(0, 88, 1'b0, 1'b0);
    run_phase(17, 17, 1'b0, 1'b1);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(12'd0, 12'd0);
    send_frame(STYLE_BINARY, -1);
    configure(12'd2, 12'd1);
    send_frame(STYLE_NOISE, -1);
    drain_and_settle();

    $display("summary: %0d input beats, %0d register writes, %0d results over %0d frames",
             beats_sent, cfg_writes, result_cnt, frame_cnt);
    $display("summary: frames 3 to 12 wide and 3 to 7 tall, undersized register values, "
             , "gaps, stalls, holds and pauses");
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("median_and_sobel_3x3_window test passed");
    end else begin
      $display("median_and_sobel_3x3_window test failed");
    end
    $finish;
  end

endmodule
